>>> rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 12;

	// Table index and block counter widths; the counter also holds MAX_BLOCKS itself.
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = CFG_IDX_W'(1);

	// Request kinds and result codes.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] request_size;
		logic [31:0] release_address;
	} req_t;

	typedef struct packed {
		logic [31:0] payload_address;
		logic        status;
	} resp_t;

	// One entry of the block table as it sits in memory.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/ffba_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address written in the same cycle returns the old contents.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (ffba_pkg::req_t)
// out       output     out_valid / out_ready  out_data  (ffba_pkg::resp_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is handled at a time. The block table lives in a single RAM with
// a registered read, so a scan reads one entry per cycle. An allocate that finds
// no free block that fits appends a new one after scanning the whole table.
// A zero-size allocate, a free above the break or a free on an empty table skip
// the scan and go straight to the finish state.
// Reset empties the table by clearing the block count; the RAM is not swept.
// The result sits in an output register, so the next request is taken while
// the previous result still waits for out_ready. cfg_ready is always high.
module first_fit_block_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire ffba_pkg::req_t                  in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output ffba_pkg::resp_t                      out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_FINISH
	} state_t;

	localparam int IDX_W = ffba_pkg::IDX_W;
	localparam int CNT_W = ffba_pkg::CNT_W;
	localparam int ENT_W = $bits(ffba_pkg::entry_t);

	state_t                state_q;
	ffba_pkg::req_t        req_q;
	ffba_pkg::resp_t       res_q;
	logic [31:0]           heap_limit_q;
	logic [31:0]           brk_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      issue_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	// RAM ports.
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	ffba_pkg::entry_t      mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [ENT_W-1:0]      mem_rdata;
	ffba_pkg::entry_t      ent;

	// Decoded conditions.
	logic                  in_xfer;
	logic                  is_alloc;
	logic                  last_entry;
	logic                  alloc_hit;
	logic                  free_hit;
	logic                  issue_more;
	logic [33:0]           new_end;
	logic                  append_ok;
	logic [31:0]           ent_payload;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign is_alloc  = (req_q.kind == ffba_pkg::KIND_ALLOC);

	assign ent         = ffba_pkg::entry_t'(mem_rdata);
	assign ent_payload = ent.start + 32'(ffba_pkg::HEADER_BYTES);
	assign last_entry  = ({1'b0, rd_idx_s1} == (count_q - CNT_W'(1)));
	assign alloc_hit   = rd_vld_s1 && ent.free && (ent.size >= req_q.request_size);
	assign free_hit    = rd_vld_s1 && (ent_payload == req_q.release_address);
	assign issue_more  = (issue_q < count_q);

	// The break can pass 32 bits only through the sum, so 34 bits hold it exactly.
	assign new_end   = {2'b00, brk_q} + 34'(ffba_pkg::HEADER_BYTES)
	                 + {2'b00, req_q.request_size};
	assign append_ok = (count_q < CNT_W'(ffba_pkg::MAX_BLOCKS))
	                 && (new_end <= 34'(32'hFFFF_FFFF))
	                 && (new_end <= {2'b00, heap_limit_q});

	// Reads start at entry zero when a request is taken; during a scan the next
	// entry is fetched while the current one is being checked.
	assign mem_raddr = (state_q == ST_SCAN) ? issue_q[IDX_W-1:0] : '0;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = ent;
		case (state_q)
			ST_SCAN: begin
				if (is_alloc && alloc_hit) begin
					mem_we         = 1'b1;
					mem_wdata.free = 1'b0;
				end else if (!is_alloc && free_hit && !ent.free) begin
					mem_we         = 1'b1;
					mem_wdata.free = 1'b1;
				end
			end
			ST_APPEND: begin
				mem_we          = append_ok;
				mem_waddr       = count_q[IDX_W-1:0];
				mem_wdata.start = brk_q;
				mem_wdata.size  = req_q.request_size;
				mem_wdata.free  = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ffba_pkg::MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(ENT_W'(mem_wdata)),
		.re   (1'b1),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			heap_limit_q <= 32'hFFFF_FFFF;
			brk_q        <= 32'h0;
			count_q      <= '0;
			issue_q      <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			out_valid    <= 1'b0;
			out_data     <= '0;
			req_q        <= '0;
			res_q        <= '0;
		end else begin
			// The output register loads in the finish state once it is empty or
			// being emptied; otherwise it clears when its transfer completes.
			if (state_q == ST_FINISH && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end

			// The user must write registers only while no request is in flight; the block
			// does not enforce it. The base only matters while the table is empty, where it sets the break.
			if (cfg_valid) begin
				if (cfg_index == ffba_pkg::REG_HEAP_BASE) begin
					if (count_q == '0) begin
						brk_q <= cfg_data;
					end
				end else if (cfg_index == ffba_pkg::REG_HEAP_LIMIT) begin
					heap_limit_q <= cfg_data;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						req_q                 <= in_data;
						res_q.payload_address <= 32'h0;
						res_q.status          <= ffba_pkg::STATUS_FAIL;
						rd_vld_s1             <= 1'b1;
						rd_idx_s1             <= '0;
						issue_q               <= CNT_W'(1);
						if (in_data.kind == ffba_pkg::KIND_ALLOC) begin
							if (in_data.request_size == 32'h0) begin
								state_q <= ST_FINISH;
							end else if (count_q == '0) begin
								state_q <= ST_APPEND;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							if (in_data.release_address > brk_q || count_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue_more;
					rd_idx_s1 <= issue_q[IDX_W-1:0];
					if (issue_more) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (is_alloc && alloc_hit) begin
						res_q.payload_address <= ent_payload;
						res_q.status          <= ffba_pkg::STATUS_OK;
						state_q               <= ST_FINISH;
					end else if (!is_alloc && free_hit) begin
						// The first matching block decides; a block already free fails.
						res_q.status <= ent.free ? ffba_pkg::STATUS_FAIL : ffba_pkg::STATUS_OK;
						state_q      <= ST_FINISH;
					end else if (!rd_vld_s1 || last_entry) begin
						state_q <= is_alloc ? ST_APPEND : ST_FINISH;
					end
				end
				ST_APPEND: begin
					if (append_ok) begin
						count_q               <= count_q + CNT_W'(1);
						brk_q                 <= new_end[31:0];
						res_q.payload_address <= brk_q + 32'(ffba_pkg::HEADER_BYTES);
						res_q.status          <= ffba_pkg::STATUS_OK;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid || out_ready) begin
						out_data <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The table never holds more blocks than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ffba_pkg::MAX_BLOCKS))
		else $error("block count exceeds table depth");

	// Table writes happen only while a scan or an append is under way.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_APPEND))
		else $error("table write outside scan or append");

	// A successful append adds exactly one block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND && append_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance block count");

	// Every taken request leaves the idle state on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("request taken but not started");

	// A scan never reads beyond the blocks in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_vld_s1) |-> ({1'b0, rd_idx_s1} < count_q))
		else $error("scan read past the last block");

endmodule

`default_nettype wire
